// ===== rtl/sliding_window_minimum_assert.svh =====
// assertion macros for the sliding window minimum block
// expects clk and arst_n in the scope of each use
`ifndef SLIDING_WINDOW_MINIMUM_ASSERT_SVH
`define SLIDING_WINDOW_MINIMUM_ASSERT_SVH

`ifndef SYNTHESIS

`define SWM_ASSERT_ALWAYS(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("invariant violated");

`define SWM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`else

`define SWM_ASSERT_ALWAYS(lbl, cond)

`define SWM_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/swm_pkg.sv =====
// shared types, constants and helpers for the sliding window minimum block
// no dependencies
package swm_pkg;

	localparam int WINDOW_MAX = 64;
	localparam int SAMPLE_W   = 32;
	localparam int CFG_W      = 7;
	localparam int IDX_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CNT_W      = $clog2(WINDOW_MAX + 1);

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [CFG_W-1:0]           cfg_t;
	typedef logic [IDX_W-1:0]           tap_idx_t;
	typedef logic [CNT_W-1:0]           count_t;

	typedef struct packed {
		logic     valid;
		logic     last;
		tap_idx_t tap;
	} stage_ctrl_t;

	// index of the cell that holds the minimum over the effective window
	function automatic tap_idx_t window_tap(input cfg_t ws);
		tap_idx_t tap;
		if (ws == '0) begin
			tap = '0;
		end else if (int'(ws) > WINDOW_MAX) begin
			tap = tap_idx_t'(WINDOW_MAX - 1);
		end else begin
			tap = tap_idx_t'(ws - 1'b1);
		end
		return tap;
	endfunction

endpackage

// ===== rtl/swm_if.sv =====
// stream interfaces for samples in and window minimums out
// depends on swm_pkg
interface swm_sample_if import swm_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample;
	logic    end_of_sequence;

	modport source(output valid, output sample, output end_of_sequence, input ready);
	modport sink(input valid, input sample, input end_of_sequence, output ready);
endinterface

interface swm_result_if import swm_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t window_min;
	logic    last_result;

	modport source(output valid, output window_min, output last_result, input ready);
	modport sink(input valid, input window_min, input last_result, output ready);
endinterface

// ===== rtl/swm_cell.sv =====
// one comparator cell: keeps the minimum of the newest samples up to its depth
// depends on swm_pkg
module swm_cell import swm_pkg::*; (
	input  logic    clk,
	input  logic    shift_en,
	input  sample_t new_sample,
	input  sample_t prev_min,
	output sample_t min_q
);

	always_ff @(posedge clk) begin
		if (shift_en) begin
			min_q <= (prev_min < new_sample) ? prev_min : new_sample;
		end
	end

endmodule

// ===== rtl/swm_out_stage.sv =====
// tap select stage and output register with flow control
// depends on swm_pkg and swm_if
module swm_out_stage import swm_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  stage_ctrl_t         ctrl_in,
	input  sample_t             mins [WINDOW_MAX],
	output logic                load_ok,
	swm_result_if.source        results
);

	stage_ctrl_t ctrl_s1;
	logic        valid_s2;
	sample_t     min_s2;
	logic        last_s2;
	logic        adv_s1;

	assign adv_s1  = !valid_s2 || results.ready;
	assign load_ok = !ctrl_s1.valid || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1  <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_ok) begin
				ctrl_s1 <= ctrl_in;
			end
			if (adv_s1) begin
				valid_s2 <= ctrl_s1.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && ctrl_s1.valid) begin
			min_s2  <= mins[ctrl_s1.tap];
			last_s2 <= ctrl_s1.last;
		end
	end

	assign results.valid       = valid_s2;
	assign results.window_min  = min_s2;
	assign results.last_result = last_s2;

endmodule

// ===== rtl/sliding_window_minimum.sv =====
// top level of the sliding window minimum filter: cell chain, count, output stage
// depends on swm_pkg, swm_if, swm_cell, swm_out_stage and the assertion header
//
// channel   direction  payload                          transaction
// samples   in         sample, end_of_sequence          valid & ready
// results   out        window_min, last_result          valid & ready
// cfg       in         cfg_wdata (window_size)          cfg_we
//
// one sample per clock sustained while the sink takes results; a result passes the
// select stage and output register; each cell updates its running minimum in parallel,
// so the rate is set by the single compare per cell and the registered tap select
// reset clears the count, the window size (to one) and all valid flags
// samples stall only when both the select stage and the output register hold
// results that the sink has not taken
`include "sliding_window_minimum_assert.svh"

module sliding_window_minimum import swm_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  cfg_t          cfg_wdata,
	swm_sample_if.sink    samples,
	swm_result_if.source  results
);

	cfg_t        window_size_q;
	count_t      seen_q;
	count_t      seen_next;
	tap_idx_t    tap;
	logic        accept;
	logic        load_ok;
	logic        produce;
	stage_ctrl_t ctrl_in;
	sample_t     mins [WINDOW_MAX];

	assign samples.ready = load_ok;
	assign accept        = samples.valid && load_ok;
	assign tap           = window_tap(window_size_q);
	assign seen_next     = (seen_q == count_t'(WINDOW_MAX)) ? seen_q : seen_q + 1'b1;
	assign produce       = seen_next > count_t'(tap);

	assign ctrl_in.valid = accept && produce;
	assign ctrl_in.last  = samples.end_of_sequence;
	assign ctrl_in.tap   = tap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= cfg_t'(1);
			seen_q        <= '0;
		end else begin
			if (cfg_we) begin
				window_size_q <= cfg_wdata;
			end
			if (accept) begin
				seen_q <= samples.end_of_sequence ? '0 : seen_next;
			end
		end
	end

	for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_cell
		sample_t prev_min;
		if (j == 0) begin : g_head
			assign prev_min = samples.sample;
		end else begin : g_body
			assign prev_min = mins[j-1];
		end
		swm_cell u_cell (
			.clk       (clk),
			.shift_en  (accept),
			.new_sample(samples.sample),
			.prev_min  (prev_min),
			.min_q     (mins[j])
		);
	end

	swm_out_stage u_out_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl_in (ctrl_in),
		.mins    (mins),
		.load_ok (load_ok),
		.results (results)
	);

	`SWM_ASSERT_ALWAYS(a_seen_bound, seen_q <= count_t'(WINDOW_MAX))
	`SWM_ASSERT_NEXT(a_eos_clears, accept && samples.end_of_sequence, seen_q == '0)
	`SWM_ASSERT_NEXT(a_head_loads, accept, mins[0] == $past(samples.sample))
	`SWM_ASSERT_NEXT(a_result_hold, results.valid && !results.ready, results.valid)
	`SWM_ASSERT_NEXT(a_result_stable, results.valid && !results.ready, $stable(results.window_min))

endmodule
